// ----- sv/tac_pkg.sv -----
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, codes and the evaluation program of the arbitrage check.
// ----------------------------------------------------------------------------
package tac_pkg;

    // stream word widths
    localparam int IN_W   = 320;
    localparam int OUT_W  = 456;
    localparam int PAIR_W = 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPITAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEE_RATE = 1'b1;
    localparam logic [31:0] FEE_RESET = 32'd3221225;

    // unused market code
    localparam logic [PAIR_W-1:0] PAIR_NONE = 2'd3;

    // limit codes
    localparam logic [1:0] LIM_CAPITAL = 2'd0;
    localparam logic [1:0] LIMD_P0_ASK = 2'd1;
    localparam logic [1:0] LIMD_P1_ASK = 2'd2;
    localparam logic [1:0] LIMD_P2_BID = 2'd3;
    localparam logic [1:0] LIMR_P2_ASK = 2'd1;
    localparam logic [1:0] LIMR_P1_BID = 2'd2;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MIN  = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_MULF, OP_MUL32, OP_DIV, OP_MIN, OP_LIM, OP_PROFD, OP_PROFR
    } t_op;

    typedef enum logic [4:0] {
        SRC_AP0, SRC_AP1, SRC_AP2, SRC_AV0, SRC_AV1, SRC_AV2,
        SRC_BP0, SRC_BP1, SRC_BP2, SRC_BV1, SRC_BV2,
        SRC_KEEP, SRC_T, SRC_V, SRC_UD, SRC_UR, SRC_ZERO
    } t_src;

    typedef enum logic [2:0] {
        DST_C0, DST_C1, DST_C3, DST_C4, DST_C7, DST_T, DST_V, DST_NONE
    } t_dst;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_ISSUE, ST_WAIT, ST_FINISH
    } t_ctrl_state;

    typedef enum logic [2:0] {
        ALU_IDLE, ALU_MUL, ALU_MFIN, ALU_DIV, ALU_DONE
    } t_alu_state;

    typedef struct packed {
        t_op  op;
        t_src srca;
        t_src srcb;
        t_dst dst;
    } t_step;

    typedef struct packed {
        logic  store;
        logic  start;
        logic  exec;
        logic  write;
        logic  load_out;
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic all_valid;
        logic any_pos;
        logic alu_done;
    } t_dp_stat;

    localparam int NUM_STEPS = 23;
    localparam int PC_W      = $clog2(NUM_STEPS);

    function automatic t_step mk(input t_op op, input t_src a, input t_src b,
                                 input t_dst d);
        t_step s;
        s.op   = op;
        s.srca = a;
        s.srcb = b;
        s.dst  = d;
        return s;
    endfunction

    // evaluation program: limits, then direct cycle, then reverse cycle
    function automatic t_step prog(input logic [PC_W-1:0] pc);
        t_step s;
        case (pc)
            5'd0:    s = mk(OP_MULF,  SRC_AV0, SRC_AP0,  DST_C0);
            5'd1:    s = mk(OP_MULF,  SRC_AV1, SRC_AP1,  DST_T);
            5'd2:    s = mk(OP_MULF,  SRC_T,   SRC_BP2,  DST_C1);
            5'd3:    s = mk(OP_MULF,  SRC_BV2, SRC_BP2,  DST_C3);
            5'd4:    s = mk(OP_MULF,  SRC_AV2, SRC_AP2,  DST_C4);
            5'd5:    s = mk(OP_MULF,  SRC_BV1, SRC_BP1,  DST_T);
            5'd6:    s = mk(OP_MULF,  SRC_T,   SRC_AP0,  DST_C7);
            5'd7:    s = mk(OP_MIN,   SRC_ZERO, SRC_ZERO, DST_NONE);
            5'd8:    s = mk(OP_LIM,   SRC_ZERO, SRC_ZERO, DST_NONE);
            5'd9:    s = mk(OP_DIV,   SRC_UD,  SRC_AP0,  DST_V);
            5'd10:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd11:   s = mk(OP_DIV,   SRC_V,   SRC_AP1,  DST_V);
            5'd12:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd13:   s = mk(OP_MULF,  SRC_V,   SRC_BP2,  DST_V);
            5'd14:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd15:   s = mk(OP_PROFD, SRC_ZERO, SRC_ZERO, DST_NONE);
            5'd16:   s = mk(OP_DIV,   SRC_UR,  SRC_AP2,  DST_V);
            5'd17:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd18:   s = mk(OP_MULF,  SRC_V,   SRC_BP1,  DST_V);
            5'd19:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd20:   s = mk(OP_MULF,  SRC_V,   SRC_BP0,  DST_V);
            5'd21:   s = mk(OP_MUL32, SRC_V,   SRC_KEEP, DST_V);
            5'd22:   s = mk(OP_PROFR, SRC_ZERO, SRC_ZERO, DST_NONE);
            default: s = mk(OP_LIM,   SRC_ZERO, SRC_ZERO, DST_NONE);
        endcase
        return s;
    endfunction

endpackage

// ----- sv/tac_alu.sv -----
// ----------------------------------------------------------------------------
// tac_alu
// Shared fixed-point unit: 64x64 multiply from four 32x32 partial products
// with saturating shift, and a restoring divider one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tac_alu #(
    parameter int FRAC_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tac_pkg::t_op  i_op,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [63:0]   o_res
);

    localparam int SHR_HI = 64 - FRAC_BITS;
    localparam int FH     = 64 + FRAC_BITS;

    tac_pkg::t_alu_state r_state, n_state;

    logic [63:0]  r_a, r_b, r_rem, r_lo, r_q, r_res;
    logic [127:0] r_acc;
    logic [1:0]   r_k;
    logic         r_f32;
    logic [5:0]   r_cnt;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh, acc_sum;
    logic [63:0]  div_hi, div_lo, rem2, mres;
    logic [64:0]  diff;
    logic         take, div_sat;

    // partial product and accumulate
    assign a_half  = r_k[0] ? r_a[63:32] : r_a[31:0];
    assign b_half  = r_k[1] ? r_b[63:32] : r_b[31:0];
    assign pp      = a_half * b_half;
    always_comb begin
        case (r_k)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end
    assign acc_sum = r_acc + pp_sh;

    // saturating shift of the full product
    always_comb begin
        if (r_f32) begin
            mres = (|r_acc[127:96]) ? tac_pkg::ALL_ONES : r_acc[95:32];
        end else begin
            mres = (|r_acc[127:FH]) ? tac_pkg::ALL_ONES : r_acc[FRAC_BITS +: 64];
        end
    end

    // divider set-up and one restoring step
    assign div_hi  = 64'(i_a >> SHR_HI);
    assign div_lo  = i_a << FRAC_BITS;
    assign div_sat = (i_b == 64'd0) || (div_hi >= i_b);
    assign rem2    = {r_rem[62:0], r_lo[63]};
    assign diff    = {1'b0, rem2} - {1'b0, r_b};
    assign take    = r_rem[63] | ~diff[64];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tac_pkg::ALU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tac_pkg::ALU_IDLE: begin
                if (i_start) begin
                    if (i_op == tac_pkg::OP_DIV) begin
                        n_state = div_sat ? tac_pkg::ALU_DONE : tac_pkg::ALU_DIV;
                    end else begin
                        n_state = tac_pkg::ALU_MUL;
                    end
                end
            end
            tac_pkg::ALU_MUL:  if (r_k == 2'd3) n_state = tac_pkg::ALU_MFIN;
            tac_pkg::ALU_MFIN: n_state = tac_pkg::ALU_DONE;
            tac_pkg::ALU_DIV:  if (r_cnt == 6'd63) n_state = tac_pkg::ALU_DONE;
            tac_pkg::ALU_DONE: n_state = tac_pkg::ALU_IDLE;
            default:           n_state = tac_pkg::ALU_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tac_pkg::ALU_IDLE: begin
                if (i_start) begin
                    r_b   <= i_b;
                    r_a   <= i_a;
                    r_acc <= '0;
                    r_k   <= 2'd0;
                    r_f32 <= (i_op == tac_pkg::OP_MUL32);
                    r_rem <= div_hi;
                    r_lo  <= div_lo;
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_res <= tac_pkg::ALL_ONES;
                end
            end
            tac_pkg::ALU_MUL: begin
                r_acc <= acc_sum;
                r_k   <= r_k + 2'd1;
            end
            tac_pkg::ALU_MFIN: r_res <= mres;
            tac_pkg::ALU_DIV: begin
                r_rem <= take ? diff[63:0] : rem2;
                r_lo  <= {r_lo[62:0], 1'b0};
                r_q   <= {r_q[62:0], take};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) r_res <= {r_q[62:0], take};
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == tac_pkg::ALU_DONE);
    assign o_res  = r_res;

endmodule

// ----- sv/tac_datapath.sv -----
// ----------------------------------------------------------------------------
// tac_datapath
// Quote stores, configuration, working registers, profit and totals logic.
// ----------------------------------------------------------------------------
module tac_datapath #(
    parameter int FRAC_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [tac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tac_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [tac_pkg::IN_W-1:0]     i_in_data,
    input  logic [tac_pkg::PAIR_W-1:0]   i_pair,
    input  tac_pkg::t_dp_cmd             i_cmd,
    output tac_pkg::t_dp_stat            o_stat,
    output logic [tac_pkg::OUT_W-1:0]    o_out_data
);

    // quote stores, one entry per market
    logic [62:0] r_time [3];
    logic [63:0] r_ap [3], r_av [3], r_bp [3], r_bv [3];
    logic [2:0]  r_qvalid;

    logic [63:0] r_capital;
    logic [31:0] r_fee;
    logic [63:0] r_c0, r_c1, r_c3, r_c4, r_c7, r_t, r_v, r_ud, r_ur;
    logic [1:0]  r_limd, r_limr;
    logic [63:0] r_profd, r_profr, r_totd, r_totr;
    logic [tac_pkg::OUT_W-1:0] r_out;

    logic [63:0] keep, opa, opb, alu_res;
    logic        alu_done;
    logic [63:0] ud_min, ur_min, m1, m2, used, d_pos, d_neg, prof;
    logic [63:0] pos_d, pos_r, tot_d, tot_r;
    logic [64:0] sum_d, sum_r;

    assign keep = 64'(33'h1_0000_0000 - {1'b0, r_fee});

    function automatic logic [63:0] pick(input tac_pkg::t_src s);
        case (s)
            tac_pkg::SRC_AP0:  return r_ap[0];
            tac_pkg::SRC_AP1:  return r_ap[1];
            tac_pkg::SRC_AP2:  return r_ap[2];
            tac_pkg::SRC_AV0:  return r_av[0];
            tac_pkg::SRC_AV1:  return r_av[1];
            tac_pkg::SRC_AV2:  return r_av[2];
            tac_pkg::SRC_BP0:  return r_bp[0];
            tac_pkg::SRC_BP1:  return r_bp[1];
            tac_pkg::SRC_BP2:  return r_bp[2];
            tac_pkg::SRC_BV1:  return r_bv[1];
            tac_pkg::SRC_BV2:  return r_bv[2];
            tac_pkg::SRC_KEEP: return keep;
            tac_pkg::SRC_T:    return r_t;
            tac_pkg::SRC_V:    return r_v;
            tac_pkg::SRC_UD:   return r_ud;
            tac_pkg::SRC_UR:   return r_ur;
            default:           return 64'd0;
        endcase
    endfunction

    assign opa = pick(i_cmd.step.srca);
    assign opb = pick(i_cmd.step.srcb);

    tac_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (i_cmd.step.op),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // usable capital of both cycles
    assign m1     = (r_capital < r_c0) ? r_capital : r_c0;
    assign m2     = (r_c1 < r_c3) ? r_c1 : r_c3;
    assign ud_min = (m1 < m2) ? m1 : m2;
    assign ur_min = (r_capital < ((r_c4 < r_c7) ? r_c4 : r_c7)) ? r_capital :
                    ((r_c4 < r_c7) ? r_c4 : r_c7);

    // signed saturated profit of the cycle in hand
    assign used  = (i_cmd.step.op == tac_pkg::OP_PROFR) ? r_ur : r_ud;
    assign d_pos = r_v - used;
    assign d_neg = used - r_v;
    always_comb begin
        if (r_v >= used) begin
            prof = d_pos[63] ? tac_pkg::INT_MAX : d_pos;
        end else begin
            prof = d_neg[63] ? tac_pkg::INT_MIN : d_pos;
        end
    end

    // running totals, saturating
    assign pos_d = r_profd[63] ? 64'd0 : r_profd;
    assign pos_r = r_profr[63] ? 64'd0 : r_profr;
    assign sum_d = {1'b0, r_totd} + {1'b0, pos_d};
    assign sum_r = {1'b0, r_totr} + {1'b0, pos_r};
    assign tot_d = sum_d[64] ? tac_pkg::ALL_ONES : sum_d[63:0];
    assign tot_r = sum_r[64] ? tac_pkg::ALL_ONES : sum_r[63:0];

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvalid  <= '0;
            r_capital <= 64'(100) << FRAC_BITS;
            r_fee     <= tac_pkg::FEE_RESET;
            r_totd    <= '0;
            r_totr    <= '0;
        end else begin
            if (i_cmd.store) r_qvalid[i_pair] <= 1'b1;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tac_pkg::CFG_CAPITAL:  r_capital <= i_cfg_data;
                    tac_pkg::CFG_FEE_RATE: r_fee     <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_totd <= tot_d;
                r_totr <= tot_r;
            end
        end
    end

    // quote stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_time[i_pair] <= i_in_data[62:0];
            r_ap[i_pair]   <= i_in_data[126:63];
            r_av[i_pair]   <= i_in_data[190:127];
            r_bp[i_pair]   <= i_in_data[254:191];
            r_bv[i_pair]   <= i_in_data[318:255];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            case (i_cmd.step.dst)
                tac_pkg::DST_C0: r_c0 <= alu_res;
                tac_pkg::DST_C1: r_c1 <= alu_res;
                tac_pkg::DST_C3: r_c3 <= alu_res;
                tac_pkg::DST_C4: r_c4 <= alu_res;
                tac_pkg::DST_C7: r_c7 <= alu_res;
                tac_pkg::DST_T:  r_t  <= alu_res;
                tac_pkg::DST_V:  r_v  <= alu_res;
                default: ;
            endcase
        end
        if (i_cmd.exec) begin
            case (i_cmd.step.op)
                tac_pkg::OP_MIN: begin
                    r_ud <= ud_min;
                    r_ur <= ur_min;
                end
                tac_pkg::OP_LIM: begin
                    if (r_ud >= r_capital)  r_limd <= tac_pkg::LIM_CAPITAL;
                    else if (r_ud == r_c0)  r_limd <= tac_pkg::LIMD_P0_ASK;
                    else if (r_ud == r_c1)  r_limd <= tac_pkg::LIMD_P1_ASK;
                    else                    r_limd <= tac_pkg::LIMD_P2_BID;
                    if (r_ur >= r_capital)  r_limr <= tac_pkg::LIM_CAPITAL;
                    else if (r_ur == r_c4)  r_limr <= tac_pkg::LIMR_P2_ASK;
                    else                    r_limr <= tac_pkg::LIMR_P1_BID;
                end
                tac_pkg::OP_PROFD: r_profd <= prof;
                tac_pkg::OP_PROFR: r_profr <= prof;
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out <= {5'd0, tot_r, tot_d, r_limr, r_profr, r_ur,
                      r_limd, r_profd, r_ud, r_time[0]};
        end
    end

    assign o_stat.all_valid = &r_qvalid;
    assign o_stat.any_pos   = (!r_profd[63] && (r_profd != 64'd0)) ||
                              (!r_profr[63] && (r_profr != 64'd0));
    assign o_stat.alu_done  = alu_done;
    assign o_out_data       = r_out;

endmodule

// ----- sv/tac_ctrl.sv -----
// ----------------------------------------------------------------------------
// tac_ctrl
// Sequencer: takes a tick, steps through the evaluation program and hands
// a result word to the output register when either profit is positive.
// ----------------------------------------------------------------------------
module tac_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tac_pkg::PAIR_W-1:0]  i_pair,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  tac_pkg::t_dp_stat           i_stat,
    output tac_pkg::t_dp_cmd            o_cmd
);

    tac_pkg::t_ctrl_state r_state, n_state;
    logic [tac_pkg::PC_W-1:0] r_pc, n_pc;
    logic r_out_valid, n_out_valid;
    logic is_alu, last;
    tac_pkg::t_step cur_step;

    // current program step, straight from the program counter
    assign cur_step = tac_pkg::prog(r_pc);
    assign is_alu = (cur_step.op == tac_pkg::OP_MULF) ||
                    (cur_step.op == tac_pkg::OP_MUL32) ||
                    (cur_step.op == tac_pkg::OP_DIV);
    assign last   = (r_pc == tac_pkg::PC_W'(tac_pkg::NUM_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tac_pkg::ST_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_pc           = r_pc;
        n_out_valid    = r_out_valid & ~i_out_ready;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.step     = cur_step;
        case (r_state)
            tac_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_pair != tac_pkg::PAIR_NONE)) begin
                    o_cmd.store = 1'b1;
                    n_state     = tac_pkg::ST_CHECK;
                end
            end
            tac_pkg::ST_CHECK: begin
                n_pc    = '0;
                n_state = i_stat.all_valid ? tac_pkg::ST_ISSUE : tac_pkg::ST_IDLE;
            end
            tac_pkg::ST_ISSUE: begin
                if (is_alu) begin
                    o_cmd.start = 1'b1;
                    n_state     = tac_pkg::ST_WAIT;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_pc       = last ? '0 : r_pc + 1'b1;
                    n_state    = last ? tac_pkg::ST_FINISH : tac_pkg::ST_ISSUE;
                end
            end
            tac_pkg::ST_WAIT: begin
                if (i_stat.alu_done) begin
                    o_cmd.write = 1'b1;
                    n_pc        = last ? '0 : r_pc + 1'b1;
                    n_state     = last ? tac_pkg::ST_FINISH : tac_pkg::ST_ISSUE;
                end
            end
            tac_pkg::ST_FINISH: begin
                if (!i_stat.any_pos) begin
                    n_state = tac_pkg::ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tac_pkg::ST_IDLE;
                end
            end
            default: n_state = tac_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.alu_done |-> (r_state == tac_pkg::ST_WAIT))
        else $error("unit finished outside a wait");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("pending result word overwritten");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < tac_pkg::PC_W'(tac_pkg::NUM_STEPS))
        else $error("program counter out of range");
    a_rise_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == tac_pkg::ST_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

// ----- sv/triangular_arbitrage_check.sv -----
// ----------------------------------------------------------------------------
// triangular_arbitrage_check
// Keeps the latest quote of three markets and checks both triangular cycles.
// ----------------------------------------------------------------------------
// One tick word is taken at a time. A tick for market code 3 is taken and
// dropped; a tick before all three markets hold a quote is stored but not
// evaluated. Otherwise evaluation runs a 23-step program on one shared
// arithmetic unit: sixteen 64x64 multiplies (four 32x32 partial products),
// three divisions (one quotient bit a cycle, the bit loop skipped when the
// quotient saturates) and four steps that do not use the unit. The serial
// divider takes most of the evaluation time. A result word is sent only
// when either cycle shows a positive profit; it waits in an output register
// while the next tick is taken, and if it is still waiting when the next
// result is ready, evaluation holds in its finish step and no further tick
// is taken.
module triangular_arbitrage_check #(
    parameter int FRAC_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick input
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tick_time, best ask, ask size, best bid, bid size
    input  logic [tac_pkg::IN_W-1:0]      i_s_axis_tdata,
    // pair
    input  logic [tac_pkg::PAIR_W-1:0]    i_s_axis_tuser,
    // result output
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // btc_quote_time, used_direct, net_direct, limit_direct, used_reverse,
    // net_reverse, limit_reverse, total_direct, total_reverse
    output logic [tac_pkg::OUT_W-1:0]     o_m_axis_tdata,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [tac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tac_pkg::CFG_W-1:0]     i_cfg_data
);

    tac_pkg::t_dp_cmd  cmd;
    tac_pkg::t_dp_stat stat;

    tac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_pair      (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tac_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_pair      (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
